FILE: src/wic_pkg.sv
// Package for the window island caller: field widths, register indexes and
// the structs passed between the top level and the island core. No dependencies.
package wic_pkg;

    localparam int TAGS_W   = 24;
    localparam int POS_W    = 32;
    localparam int CHROM_W  = 5;
    localparam int GAP_W    = 8;
    localparam int SUM_W    = 32;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;

    localparam int CHROM_COUNT_DEFAULT = 32;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_WINDOW_TAGS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_ISLAND_TAGS = 2'd2;

    localparam logic [TAGS_W-1:0] MIN_WINDOW_TAGS_RESET = 24'd1;
    localparam logic [GAP_W-1:0]  GAP_LIMIT_RESET       = 8'd2;
    localparam logic [SUM_W-1:0]  MIN_ISLAND_TAGS_RESET = 32'd0;

    typedef struct packed {
        logic [TAGS_W-1:0] min_window_tags;
        logic [GAP_W-1:0]  gap_limit;
        logic [SUM_W-1:0]  min_island_tags;
    } cfg_t;

    typedef struct packed {
        logic [TAGS_W-1:0]  window_tags;
        logic [POS_W-1:0]   window_start;
        logic [POS_W-1:0]   window_end;
        logic [CHROM_W-1:0] chrom_index;
        logic               last_window;
    } win_t;

    typedef struct packed {
        logic [CHROM_W-1:0] island_chrom;
        logic [POS_W-1:0]   island_start;
        logic [POS_W-1:0]   island_stop;
        logic [TAGS_W-1:0]  island_windows;
        logic [SUM_W-1:0]   island_tags;
    } island_t;

endpackage

FILE: src/wic_if.sv
// Channel interfaces of the window island caller: window input and island output.
// Depends on wic_pkg for the field widths.
interface wic_win_if;
    import wic_pkg::*;

    logic               valid;
    logic               ready;
    logic [TAGS_W-1:0]  window_tags;
    logic [POS_W-1:0]   window_start;
    logic [POS_W-1:0]   window_end;
    logic [CHROM_W-1:0] chrom_index;
    logic               last_window;

    modport source (output valid, window_tags, window_start, window_end, chrom_index,
                    last_window, input ready);
    modport sink   (input valid, window_tags, window_start, window_end, chrom_index,
                    last_window, output ready);
endinterface

interface wic_island_if;
    import wic_pkg::*;

    logic               valid;
    logic               ready;
    logic [CHROM_W-1:0] island_chrom;
    logic [POS_W-1:0]   island_start;
    logic [POS_W-1:0]   island_stop;
    logic [TAGS_W-1:0]  island_windows;
    logic [SUM_W-1:0]   island_tags;

    modport source (output valid, island_chrom, island_start, island_stop, island_windows,
                    island_tags, input ready);
    modport sink   (input valid, island_chrom, island_start, island_stop, island_windows,
                    island_tags, output ready);
endinterface

FILE: src/window_island_caller_top.sv
// Top level of the window island caller: configuration registers, input
// register, island core and result register. Depends on wic_pkg, wic_if, wic_core.
//
// Usage: windows arrive in order on the win channel, one transfer per window,
// each carrying its tag count, start, end, chromosome and last-window mark.
// Qualifying islands leave on the island channel, at most one transfer per
// window. A transfer takes place on a rising edge of clk with valid and ready high.
// Configuration is written through cfg_we, cfg_index and cfg_data, one register
// per cycle, while no window is in flight; indexes beyond the list are ignored.
// An island appears on the island channel once the window that closes it has
// passed the input register and then the result register.
// Throughput: one window per cycle unless the receiver stalls; the island state
// update, compares and saturating adds, lies between the input and result registers.
// When the receiver stalls, the result register holds its island and the input
// register holds one more window; after that win.ready falls until the island
// is taken. A window that produces no island still waits in the input register
// while a result is held.
// Reset (rst_n low, asynchronous) empties both registers, closes any open
// island without emitting it and loads the register defaults: minimum window
// tags 1, gap limit 2, minimum island tags 0.
module window_island_caller_top #(
    parameter int CHROM_COUNT = wic_pkg::CHROM_COUNT_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    wic_win_if.sink                       win,
    wic_island_if.source                  island,
    input  logic                          cfg_we,
    input  logic [wic_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wic_pkg::CFG_W-1:0]     cfg_data
);
    import wic_pkg::*;

    cfg_t    cfg_reg;
    logic    in_valid_reg;
    win_t    in_data_reg;
    logic    out_valid_reg;
    island_t out_data_reg;

    logic    advance;
    logic    emit;
    island_t res;

    // Configuration writes; each field keeps the low bits of the data word that fit it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_window_tags <= MIN_WINDOW_TAGS_RESET;
            cfg_reg.gap_limit       <= GAP_LIMIT_RESET;
            cfg_reg.min_island_tags <= MIN_ISLAND_TAGS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MIN_WINDOW_TAGS: cfg_reg.min_window_tags <= cfg_data[TAGS_W-1:0];
                REG_GAP_LIMIT:       cfg_reg.gap_limit       <= cfg_data[GAP_W-1:0];
                REG_MIN_ISLAND_TAGS: cfg_reg.min_island_tags <= cfg_data[SUM_W-1:0];
                default: ;
            endcase
        end
    end

    // The pipeline moves on whenever the result register is free or being emptied.
    assign advance   = !out_valid_reg || island.ready;
    assign win.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (win.ready)
        begin
            in_valid_reg <= win.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (win.valid && win.ready)
        begin
            in_data_reg.window_tags  <= win.window_tags;
            in_data_reg.window_start <= win.window_start;
            in_data_reg.window_end   <= win.window_end;
            in_data_reg.chrom_index  <= win.chrom_index;
            in_data_reg.last_window  <= win.last_window;
        end
    end

    wic_core #(
        .CHROM_COUNT (CHROM_COUNT)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (in_valid_reg && advance),
        .win   (in_data_reg),
        .cfg   (cfg_reg),
        .emit  (emit),
        .res   (res)
    );

    // Result register: loaded with the closing island, held while the receiver stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_data_reg <= res;
        end
    end

    assign island.valid          = out_valid_reg;
    assign island.island_chrom   = out_data_reg.island_chrom;
    assign island.island_start   = out_data_reg.island_start;
    assign island.island_stop    = out_data_reg.island_stop;
    assign island.island_windows = out_data_reg.island_windows;
    assign island.island_tags    = out_data_reg.island_tags;

endmodule

FILE: src/wic_core.sv
// Island state and the per-window update: density test, gap counting,
// saturating sums and the emit decision. Depends on wic_pkg.
module wic_core #(
    parameter int CHROM_COUNT = wic_pkg::CHROM_COUNT_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  wic_pkg::win_t    win,
    input  wic_pkg::cfg_t    cfg,
    output logic             emit,
    output wic_pkg::island_t res
);
    import wic_pkg::*;

    localparam logic [8:0] ChromLimit = 9'(CHROM_COUNT);

    logic               in_island_reg, in_island_next;
    logic [CHROM_W-1:0] open_chrom_reg, open_chrom_next;
    logic [POS_W-1:0]   open_start_reg, open_start_next;
    logic [POS_W-1:0]   open_stop_reg, open_stop_next;
    logic [TAGS_W-1:0]  open_windows_reg, open_windows_next;
    logic [SUM_W-1:0]   open_tags_reg, open_tags_next;
    logic [GAP_W-1:0]   empty_run_reg, empty_run_next;

    logic               chrom_ok;
    logic               live;
    logic               dense;
    logic [GAP_W-1:0]   limit;
    logic [GAP_W-1:0]   run_inc;
    logic [SUM_W:0]     tag_sum;
    logic [TAGS_W:0]    win_sum;
    logic               close;

    always_comb
    begin
        chrom_ok = {4'b0, win.chrom_index} < ChromLimit;
        live     = in_island_reg && (open_chrom_reg == win.chrom_index);
        dense    = win.window_tags >= cfg.min_window_tags;
        limit    = (cfg.gap_limit == '0) ? GAP_W'(1) : cfg.gap_limit;
        run_inc  = empty_run_reg + GAP_W'(1);
        tag_sum  = {1'b0, open_tags_reg} + (SUM_W + 1)'(win.window_tags);
        win_sum  = {1'b0, open_windows_reg} + (TAGS_W + 1)'({1'b0, empty_run_reg})
                   + (TAGS_W + 1)'(1);

        in_island_next    = in_island_reg;
        open_chrom_next   = open_chrom_reg;
        open_start_next   = open_start_reg;
        open_stop_next    = open_stop_reg;
        open_windows_next = open_windows_reg;
        open_tags_next    = open_tags_reg;
        empty_run_next    = empty_run_reg;
        close             = 1'b0;

        if (live)
        begin
            if (dense)
            begin
                open_tags_next    = tag_sum[SUM_W] ? '1 : tag_sum[SUM_W-1:0];
                open_windows_next = win_sum[TAGS_W] ? '1 : win_sum[TAGS_W-1:0];
                open_stop_next    = win.window_end;
                empty_run_next    = '0;
                close             = win.last_window;
            end
            else if (run_inc >= limit)
            begin
                close = 1'b1;
            end
            else
            begin
                empty_run_next = run_inc;
                close          = win.last_window;
            end
        end
        else if (dense)
        begin
            // A dense window with no island open on its chromosome starts one;
            // an island left open on another chromosome is simply dropped.
            in_island_next    = 1'b1;
            open_chrom_next   = win.chrom_index;
            open_start_next   = win.window_start;
            open_stop_next    = win.window_end;
            open_windows_next = TAGS_W'(1);
            open_tags_next    = SUM_W'(win.window_tags);
            empty_run_next    = '0;
            close             = win.last_window;
        end
        else
        begin
            in_island_next = 1'b0;
            empty_run_next = '0;
        end

        if (close)
        begin
            in_island_next = 1'b0;
            empty_run_next = '0;
        end

        emit = step && chrom_ok && close && (open_tags_next > cfg.min_island_tags);

        res.island_chrom   = open_chrom_next;
        res.island_start   = open_start_next;
        res.island_stop    = open_stop_next;
        res.island_windows = open_windows_next;
        res.island_tags    = open_tags_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_island_reg <= 1'b0;
            empty_run_reg <= '0;
        end
        else if (step && chrom_ok)
        begin
            in_island_reg <= in_island_next;
            empty_run_reg <= empty_run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && chrom_ok)
        begin
            open_chrom_reg   <= open_chrom_next;
            open_start_reg   <= open_start_next;
            open_stop_reg    <= open_stop_next;
            open_windows_reg <= open_windows_next;
            open_tags_reg    <= open_tags_next;
        end
    end

endmodule
